// ----- hw/rtl/hps_pkg.sv -----
// hps_pkg: shared types, constants and the CORDIC angle table for the
// heading PID steering block. No dependencies.

package hps_pkg;

  // default CORDIC iteration count (legal range 8..24)
  localparam int CORDIC_STEPS_DEF = 16;

  // CORDIC datapath widths
  localparam int CORDIC_W    = 32;   // x, y working width
  localparam int ANGLE_W     = 28;   // z at scale 2^24
  localparam int ANGLE_IDX_W = 5;    // step index into the angle function
  localparam int DXY_FRAC    = 12;   // dx, dy pre-scale

  // value widths
  localparam int POS_W   = 16;
  localparam int DPOS_W  = 17;
  localparam int HEAD_W  = 15;
  localparam int BEAR_W  = 16;
  localparam int ERR_W   = 16;
  localparam int SUM_W   = 20;
  localparam int GAIN_W  = 24;
  localparam int LEAK_W  = 16;
  localparam int LIM_W   = 14;
  localparam int STEER_W = 15;
  localparam int CFG_W   = 24;
  localparam int IDX_W   = 3;

  // shared multiplier widths
  localparam int MUL_A_W = GAIN_W + 1;
  localparam int MUL_B_W = SUM_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 48;

  // angle constants
  localparam logic signed [BEAR_W-1:0]  PI_Q12     = 16'sd12868;
  localparam logic signed [DPOS_W-1:0]  TWO_PI_Q12 = 17'sd25736;
  localparam logic signed [ANGLE_W-1:0] PI_Z       = 28'sd52707179;

  localparam logic signed [SUM_W-1:0] SUM_MAX = 20'sd524287;
  localparam logic signed [SUM_W-1:0] SUM_MIN = -20'sd524288;

  // register indexes
  localparam logic [IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [IDX_W-1:0] REG_INT_GAIN   = 3'd1;
  localparam logic [IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
  localparam logic [IDX_W-1:0] REG_LEAK       = 3'd3;
  localparam logic [IDX_W-1:0] REG_STEER_LIM  = 3'd4;

  // register reset values
  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 24'd98304;
  localparam logic [GAIN_W-1:0] INT_GAIN_RST   = 24'd55;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 24'd1966080;
  localparam logic [LEAK_W-1:0] LEAK_RST       = 16'd58982;
  localparam logic [LIM_W-1:0]  STEER_LIM_RST  = 14'd3277;

  // command codes
  localparam logic CMD_STEP  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CORDIC,
    S_ERR,
    S_MUL_P,
    S_MUL_I,
    S_MUL_D,
    S_WAIT_T,
    S_TOTAL,
    S_WAIT_L,
    S_LEAK,
    S_OUT
  } state_t;

  typedef struct packed {
    logic valid;
    logic acc_clr;
  } mac_op_t;

  // atan(2^-i) at scale 2^24; past step 7 the angle is 2^(24-i)
  function automatic logic signed [ANGLE_W-1:0] cordic_angle(
    input logic [ANGLE_IDX_W-1:0] idx
  );
    logic signed [ANGLE_W-1:0] a;
    case (idx)
      5'd0:    a = 28'sd13176795;
      5'd1:    a = 28'sd7778716;
      5'd2:    a = 28'sd4110060;
      5'd3:    a = 28'sd2086331;
      5'd4:    a = 28'sd1047214;
      5'd5:    a = 28'sd524117;
      5'd6:    a = 28'sd262123;
      5'd7:    a = 28'sd131069;
      default: a = 28'sd1 <<< (5'd24 - idx);
    endcase
    return a;
  endfunction

endpackage

// ----- hw/rtl/heading_pid_steering.sv -----
// heading_pid_steering: top level; sequencer, config registers, error
// stores and output word register. Uses hps_pkg, hps_cordic, hps_mac.
//
//   channel  signals                                      direction
//   req      req_valid/req_stall, command, car_*, goal_*  pose in
//   rsp      rsp_valid/rsp_stall, steer, saturated        command out
//   config   wr_en, wr_index, wr_data                     register write
//
// A step word runs the CORDIC loop at one rotation a cycle, then makes
// four passes through the one multiplier. Goal on the x axis skips the
// CORDIC loop; a clear word goes straight to the output state.
// Reset loads register defaults and zeroes both error stores.
// req_stall is high while a word is in work; the output register lets the
// next word in while a result waits on rsp_stall.

module heading_pid_steering import hps_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  logic                      command,
  input  logic signed [POS_W-1:0]   car_x,
  input  logic signed [POS_W-1:0]   car_y,
  input  logic signed [HEAD_W-1:0]  car_heading,
  input  logic signed [POS_W-1:0]   goal_x,
  input  logic signed [POS_W-1:0]   goal_y,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output logic signed [STEER_W-1:0] steer,
  output logic                      saturated,
  input  logic                      wr_en,
  input  logic [IDX_W-1:0]          wr_index,
  input  logic [CFG_W-1:0]          wr_data
);

  state_t state, state_next;

  logic [GAIN_W-1:0] prop_gain, int_gain, deriv_gain;
  logic [LEAK_W-1:0] leak_factor;
  logic [LIM_W-1:0]  steer_limit;

  logic signed [ERR_W-1:0]   prev_error, err;
  logic signed [SUM_W-1:0]   leaky_sum;
  logic signed [HEAD_W-1:0]  heading;
  logic signed [STEER_W-1:0] res_steer;
  logic                      res_sat;

  logic                      accept;
  logic                      cordic_start, cordic_done;
  logic signed [DPOS_W-1:0]  dx, dy;
  logic signed [BEAR_W-1:0]  bearing;

  mac_op_t                   mac_op;
  logic signed [MUL_A_W-1:0] mac_a;
  logic signed [MUL_B_W-1:0] mac_b;
  logic signed [ACC_W-1:0]   acc;

  logic signed [DPOS_W-1:0]  diff, rem, wrapped;
  logic signed [ERR_W-1:0]   d_err;
  logic signed [ACC_W-1:0]   acc_rnd;
  logic signed [31:0]        ctrl, lim32, sum_new;

  assign accept = req_valid && !req_stall;
  assign dx = DPOS_W'(goal_x) - DPOS_W'(car_x);
  assign dy = DPOS_W'(goal_y) - DPOS_W'(car_y);

  hps_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cordic_start),
    .dx      (dx),
    .dy      (dy),
    .done    (cordic_done),
    .bearing (bearing)
  );

  hps_mac u_mac (
    .clk (clk),
    .rst (rst),
    .op  (mac_op),
    .a   (mac_a),
    .b   (mac_b),
    .acc (acc)
  );

  // error wrap: truncating remainder by 2*pi, then one shift into [-pi, pi]
  always_comb begin
    diff = DPOS_W'(bearing) - DPOS_W'(heading);
    if (diff >= TWO_PI_Q12)
      rem = diff - TWO_PI_Q12;
    else if (diff <= -TWO_PI_Q12)
      rem = diff + TWO_PI_Q12;
    else
      rem = diff;
    if (rem > DPOS_W'(PI_Q12))
      wrapped = rem - TWO_PI_Q12;
    else if (rem < -DPOS_W'(PI_Q12))
      wrapped = rem + TWO_PI_Q12;
    else
      wrapped = rem;
  end

  always_comb begin
    d_err   = err - prev_error;
    acc_rnd = acc + ACC_W'(32768);
    ctrl    = acc_rnd[ACC_W-1:16];
    lim32   = 32'(steer_limit);
    sum_new = acc_rnd[ACC_W-1:16] + 32'(err);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = (command == CMD_CLEAR) ? S_OUT : S_CORDIC;
      S_CORDIC: if (cordic_done) state_next = S_ERR;
      S_ERR:    state_next = S_MUL_P;
      S_MUL_P:  state_next = S_MUL_I;
      S_MUL_I:  state_next = S_MUL_D;
      S_MUL_D:  state_next = S_WAIT_T;
      S_WAIT_T: state_next = S_TOTAL;
      S_TOTAL:  state_next = S_WAIT_L;
      S_WAIT_L: state_next = S_LEAK;
      S_LEAK:   state_next = S_OUT;
      S_OUT:    if (!rsp_valid || !rsp_stall) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    req_stall    = 1'b1;
    cordic_start = 1'b0;
    mac_op       = '0;
    mac_a        = '0;
    mac_b        = '0;
    unique case (state)
      S_IDLE: begin
        req_stall    = 1'b0;
        cordic_start = req_valid && (command == CMD_STEP);
      end
      S_MUL_P: begin
        mac_op = '{valid: 1'b1, acc_clr: 1'b1};
        mac_a  = MUL_A_W'(prop_gain);
        mac_b  = MUL_B_W'(err);
      end
      S_MUL_I: begin
        mac_op = '{valid: 1'b1, acc_clr: 1'b0};
        mac_a  = MUL_A_W'(int_gain);
        mac_b  = leaky_sum;
      end
      S_MUL_D: begin
        mac_op = '{valid: 1'b1, acc_clr: 1'b0};
        mac_a  = MUL_A_W'(deriv_gain);
        mac_b  = MUL_B_W'(d_err);
      end
      S_TOTAL: begin
        // total is read this cycle; the leak product then replaces it
        mac_op = '{valid: 1'b1, acc_clr: 1'b1};
        mac_a  = MUL_A_W'(leak_factor);
        mac_b  = leaky_sum;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain   <= PROP_GAIN_RST;
      int_gain    <= INT_GAIN_RST;
      deriv_gain  <= DERIV_GAIN_RST;
      leak_factor <= LEAK_RST;
      steer_limit <= STEER_LIM_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_PROP_GAIN:  prop_gain   <= wr_data;
        REG_INT_GAIN:   int_gain    <= wr_data;
        REG_DERIV_GAIN: deriv_gain  <= wr_data;
        REG_LEAK:       leak_factor <= wr_data[LEAK_W-1:0];
        REG_STEER_LIM:  steer_limit <= wr_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // error stores and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error <= '0;
      leaky_sum  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            heading <= car_heading;
            if (command == CMD_CLEAR) begin
              prev_error <= '0;
              leaky_sum  <= '0;
              res_steer  <= '0;
              res_sat    <= 1'b0;
            end
          end
        end
        S_ERR: err <= ERR_W'(wrapped);
        S_TOTAL: begin
          if (ctrl > lim32) begin
            res_steer <= STEER_W'(steer_limit);
            res_sat   <= 1'b1;
          end else if (ctrl < -lim32) begin
            res_steer <= -STEER_W'(steer_limit);
            res_sat   <= 1'b1;
          end else begin
            res_steer <= ctrl[STEER_W-1:0];
            res_sat   <= 1'b0;
          end
        end
        S_LEAK: begin
          prev_error <= err;
          if (sum_new > 32'(SUM_MAX))
            leaky_sum <= SUM_MAX;
          else if (sum_new < 32'(SUM_MIN))
            leaky_sum <= SUM_MIN;
          else
            leaky_sum <= sum_new[SUM_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      if (state == S_OUT && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
        steer     <= res_steer;
        saturated <= res_sat;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/hps_cordic.sv -----
// hps_cordic: iterative vectoring CORDIC, one micro-rotation per cycle.
// Returns the four-quadrant bearing of (dx, dy) in Q3.12. Uses hps_pkg.

module hps_cordic import hps_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [DPOS_W-1:0] dx,
  input  logic signed [DPOS_W-1:0] dy,
  output logic                     done,
  output logic signed [BEAR_W-1:0] bearing
);

  localparam int ITER_W = $clog2(STEPS);

  logic                       busy;
  logic [ITER_W-1:0]          iter;
  logic signed [CORDIC_W-1:0] x, y;
  logic signed [ANGLE_W-1:0]  z;

  logic signed [CORDIC_W-1:0] x0, y0, xs, ys, x_next, y_next;
  logic signed [ANGLE_W-1:0]  a, z_next, z_rnd;

  always_comb begin
    x0     = CORDIC_W'(dx) <<< DXY_FRAC;
    y0     = CORDIC_W'(dy) <<< DXY_FRAC;
    xs     = x >>> iter;
    ys     = y >>> iter;
    a      = cordic_angle(ANGLE_IDX_W'(iter));
    if (y >= 0) begin
      x_next = x + ys;
      y_next = y - xs;
      z_next = z + a;
    end else begin
      x_next = x - ys;
      y_next = y + xs;
      z_next = z - a;
    end
    z_rnd = z_next + ANGLE_W'(2048);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      // done pulses for one cycle: axis shortcut at start, or last rotation
      done <= start ? (dy == 0) : (busy && iter == ITER_W'(STEPS - 1));
      if (start) begin
        iter <= '0;
        if (dy == 0) begin
          // on the x axis: straight ahead is 0, straight behind is pi
          bearing <= (dx < 0) ? PI_Q12 : '0;
        end else begin
          busy <= 1'b1;
          if (dx < 0) begin
            // left half plane: pre-rotate by pi
            x <= -x0;
            y <= -y0;
            z <= (dy > 0) ? PI_Z : -PI_Z;
          end else begin
            x <= x0;
            y <= y0;
            z <= '0;
          end
        end
      end else if (busy) begin
        x    <= x_next;
        y    <= y_next;
        z    <= z_next;
        iter <= iter + 1'b1;
        if (iter == ITER_W'(STEPS - 1)) begin
          busy    <= 1'b0;
          bearing <= z_rnd[ANGLE_W-1:12];
        end
      end
    end
  end

endmodule

// ----- hw/rtl/hps_mac.sv -----
// hps_mac: shared signed multiplier with a registered product and a
// 48-bit accumulator that adds the registered product. Uses hps_pkg.

module hps_mac import hps_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  mac_op_t                   op,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [ACC_W-1:0]   acc
);

  logic signed [PROD_W-1:0] prod;
  mac_op_t                  op_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_q <= '0;
    end else begin
      op_q <= op;
    end
  end

  always_ff @(posedge clk) begin
    prod <= a * b;
    if (op_q.valid) begin
      acc <= (op_q.acc_clr ? '0 : acc) + ACC_W'(prod);
    end
  end

endmodule
